@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the RLE packet decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RLE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rleipd_pkg.sv @@
// Types and constants shared by the RLE packet decoder modules.
`default_nettype none

package rleipd_pkg;

  localparam logic [2:0] MAX_BPP   = 3'd4;
  localparam logic [2:0] RESET_BPP = 3'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_last;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/rleipd_front.sv @@
// Front end: configuration registers, header parsing, pixel assembly and run counting.
`default_nettype none

module rleipd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rleipd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data,
  input  rleipd_pkg::q_stat_t                 q_stat,
  output logic                                q_push,
  output rleipd_pkg::rec_t                    q_rec
);

  logic [2:0]  bpp_r, bpp_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [31:0] total_r, total_nxt;
  logic        await_r, await_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [31:0] img_left_r, img_left_nxt;

  logic        accept;
  logic        cfg_write;
  logic [2:0]  eff_size;
  logic [31:0] img_base;
  logic [7:0]  run;
  logic [7:0]  run_clip;
  logic [31:0] pix_value;
  logic [7:0]  count;
  logic [31:0] img_after;
  logic [7:0]  pkt_after;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cfg_write = cfg_valid && cfg_ready;

  assign mul_a   = (cfg_index == rleipd_pkg::CFG_WIDTH) ? cfg_data : width_r;
  assign mul_b   = (cfg_index == rleipd_pkg::CFG_HEIGHT) ? cfg_data : height_r;
  assign product = {16'd0, mul_a} * {16'd0, mul_b};

  always_comb begin
    if (bpp_r == 3'd0) begin
      eff_size = 3'd1;
    end else if (bpp_r > rleipd_pkg::MAX_BPP) begin
      eff_size = rleipd_pkg::MAX_BPP;
    end else begin
      eff_size = bpp_r;
    end
  end

  assign img_base  = (img_left_r == 32'd0) ? total_r : img_left_r;
  assign run       = {1'b0, in_byte[6:0]} + 8'd1;
  assign run_clip  = ({24'd0, run} > img_base) ? img_base[7:0] : run;
  assign pix_value = {8'd0, acc_r} | ({24'd0, in_byte} << {pos_r, 3'b000});
  assign count     = repeat_r ? pkt_left_r : 8'd1;
  assign img_after = img_left_r - {24'd0, count};
  assign pkt_after = repeat_r ? 8'd0 :
                     ((pkt_left_r != 8'd0) ? pkt_left_r - 8'd1 : 8'd0);

  always_comb begin
    bpp_nxt      = bpp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    total_nxt    = total_r;
    await_nxt    = await_r;
    repeat_nxt   = repeat_r;
    pkt_left_nxt = pkt_left_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    img_left_nxt = img_left_r;
    q_push       = 1'b0;
    q_rec.pixel_value  = pix_value;
    q_rec.repeat_count = count;
    q_rec.image_last   = (img_after == 32'd0);

    if (cfg_write) begin
      case (cfg_index)
        rleipd_pkg::CFG_BPP: begin
          bpp_nxt = cfg_data[2:0];
        end
        rleipd_pkg::CFG_WIDTH: begin
          width_nxt = cfg_data;
          total_nxt = product;
        end
        rleipd_pkg::CFG_HEIGHT: begin
          height_nxt = cfg_data;
          total_nxt  = product;
        end
        default: begin
        end
      endcase
    end

    if (accept) begin
      if (await_r) begin
        // An empty image leaves the header byte without effect.
        if (img_base != 32'd0) begin
          img_left_nxt = img_base;
          pkt_left_nxt = run_clip;
          repeat_nxt   = in_byte[7];
          await_nxt    = 1'b0;
          pos_nxt      = 2'd0;
          acc_nxt      = 24'd0;
        end
      end else if (({1'b0, pos_r} + 3'd1) < eff_size) begin
        case (pos_r)
          2'd0:    acc_nxt[7:0]   = in_byte;
          2'd1:    acc_nxt[15:8]  = in_byte;
          2'd2:    acc_nxt[23:16] = in_byte;
          default: acc_nxt        = acc_r;
        endcase
        pos_nxt = pos_r + 2'd1;
      end else begin
        pos_nxt      = 2'd0;
        acc_nxt      = 24'd0;
        pkt_left_nxt = pkt_after;
        img_left_nxt = img_after;
        await_nxt    = (pkt_after == 8'd0) || (img_after == 32'd0);
        q_push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= rleipd_pkg::RESET_BPP;
      width_r    <= 16'd0;
      height_r   <= 16'd0;
      total_r    <= 32'd0;
      await_r    <= 1'b1;
      repeat_r   <= 1'b0;
      pkt_left_r <= 8'd0;
      pos_r      <= 2'd0;
      acc_r      <= 24'd0;
      img_left_r <= 32'd0;
    end else begin
      bpp_r      <= bpp_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      total_r    <= total_nxt;
      await_r    <= await_nxt;
      repeat_r   <= repeat_nxt;
      pkt_left_r <= pkt_left_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      img_left_r <= img_left_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/rleipd_queue.sv @@
// Small result queue between the front end and the output stage.
`default_nettype none

module rleipd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rleipd_pkg::rec_t    push_rec,
  input  logic                pop,
  output rleipd_pkg::rec_t    pop_rec,
  output rleipd_pkg::q_stat_t stat
);

  localparam int unsigned PW = rleipd_pkg::Q_PTR_W;
  localparam int unsigned CW = rleipd_pkg::Q_CNT_W;
  localparam logic [PW-1:0] LAST_PTR = PW'(rleipd_pkg::Q_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(rleipd_pkg::Q_DEPTH);

  rleipd_pkg::rec_t mem_r [rleipd_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_rec    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/rleipd_back.sv @@
// Back end: output register that drains the result queue onto the result channel.
`default_nettype none

module rleipd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rleipd_pkg::q_stat_t q_stat,
  input  rleipd_pkg::rec_t    q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_pixel_value,
  output logic [7:0]          out_repeat_count,
  output logic                out_image_last
);

  logic             valid_r, valid_nxt;
  rleipd_pkg::rec_t rec_r;

  assign q_pop     = !q_stat.empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  assign out_valid        = valid_r;
  assign out_pixel_value  = rec_r.pixel_value;
  assign out_repeat_count = rec_r.repeat_count;
  assign out_image_last   = rec_r.image_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/rle_image_packet_decoder_unit.sv @@
// Top level of the RLE image packet decoder: front end, result queue and output stage.
// One request is accepted per cycle; the pixel byte that completes a result writes it into
// the queue, and the output register then loads it when empty or being drained.
// Header bytes and non-final pixel bytes produce no result. Input stalls only when the
// two-entry queue is full, which needs out_ready low while the output register is occupied.
// Synchronous active-low reset clears control state; pixel size resets to three bytes.
`default_nettype none

module rle_image_packet_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_pixel_value,
  output logic [7:0]                       out_repeat_count,
  output logic                             out_image_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rleipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);

`include "assert_macros.svh"

  rleipd_pkg::q_stat_t q_stat;
  rleipd_pkg::rec_t    q_push_rec;
  rleipd_pkg::rec_t    q_pop_rec;
  logic                q_push;
  logic                q_pop;
  logic                push_count_ok;

  assign push_count_ok = (q_push_rec.repeat_count != 8'd0) &&
                         (q_push_rec.repeat_count <= 8'd128);

  rleipd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_rec     (q_push_rec)
  );

  rleipd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .pop_rec  (q_pop_rec),
    .stat     (q_stat)
  );

  rleipd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rec            (q_pop_rec),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_last   (out_image_last)
  );

  `RLE_ASSERT(a_push_not_full, q_push, !q_stat.full, "result pushed into a full queue")
  `RLE_ASSERT(a_pop_not_empty, q_pop, !q_stat.empty, "result taken from an empty queue")
  `RLE_ASSERT(a_count_range, q_push, push_count_ok, "repeat count out of range")
  `RLE_ASSERT_NEXT(a_pop_loads_output, q_pop, out_valid, "taken result not presented")

endmodule

`default_nettype wire
